// ----- design/scrq_pkg.sv -----
// ----------------------------------------------------------------------------
// scrq_pkg
// shared types and constants of the sound command ring queue
// ----------------------------------------------------------------------------
package scrq_pkg;

    localparam int CODE_W  = 16;
    localparam int COUNT_W = 8;
    localparam int OUT6_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CODE_W-1:0] RESET_LOWER = 16'h0100;
    localparam logic [CODE_W-1:0] RESET_UPPER = 16'h1F00;
    localparam logic [CODE_W-1:0] EMPTY_CODE  = 16'h0000;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER_LIMIT = 2'd0,
        REG_UPPER_LIMIT = 2'd1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WRITE,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pull_read;
        logic mark_empty;
        logic write_copy;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_pull;
        logic empty;
        logic full;
        logic in_limits;
        logic count_zero;
        logic last_copy;
    } status_t;

endpackage

// ----- design/scrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// scrq_ctrl
// item sequencer: evaluate, write copies one per cycle, present the result
// ----------------------------------------------------------------------------
module scrq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  scrq_pkg::status_t status,
    output scrq_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);
    import scrq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.is_pull || status.full || !status.in_limits || status.count_zero)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (status.last_copy)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_EVAL:
            begin
                // pull: registered read of the oldest entry, or flag empty
                cmd.pull_read  = status.is_pull && !status.empty;
                cmd.mark_empty = status.is_pull && status.empty;
            end
            ST_WRITE:
            begin
                cmd.write_copy = 1'b1;
            end
            ST_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ----- design/scrq_datapath.sv -----
// ----------------------------------------------------------------------------
// scrq_datapath
// entry memory, ring indices, limit registers and result fields
// ----------------------------------------------------------------------------
module scrq_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  scrq_pkg::cmd_t                      cmd,
    output scrq_pkg::status_t                   status,
    input  logic                                op,
    input  logic [scrq_pkg::CODE_W-1:0]         sound_code,
    input  logic [scrq_pkg::COUNT_W-1:0]        repeat_count,
    input  logic                                cfg_we,
    input  logic [scrq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scrq_pkg::CODE_W-1:0]         cfg_data,
    output logic [scrq_pkg::CODE_W-1:0]         pulled_code,
    output logic                                queue_was_empty,
    output logic [scrq_pkg::OUT6_W-1:0]         copies_written,
    output logic [scrq_pkg::OUT6_W-1:0]         free_space
);
    import scrq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int FW = (IW > OUT6_W) ? IW : OUT6_W;
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
    localparam logic [IW:0]   DEPTH_W   = (IW + 1)'(DEPTH);

    logic [CODE_W-1:0] entry_mem [DEPTH];
    logic [CODE_W-1:0] rdata_reg;

    logic [IW-1:0]      rd_idx_reg,  rd_idx_next;
    logic [IW-1:0]      wr_idx_reg,  wr_idx_next;
    logic [CODE_W-1:0]  lower_reg,   lower_next;
    logic [CODE_W-1:0]  upper_reg,   upper_next;
    logic               op_reg,      op_next;
    logic [CODE_W-1:0]  code_reg,    code_next;
    logic [COUNT_W-1:0] left_reg,    left_next;
    logic [COUNT_W-1:0] written_reg, written_next;
    logic               pull_ok_reg, pull_ok_next;
    logic               empty_reg,   empty_next;

    logic [IW:0]   used_diff;
    logic [IW-1:0] used;
    logic [IW-1:0] free;
    logic [FW-1:0] free_ext;

    // occupancy from the two indices, wrapping at DEPTH
    always_comb
    begin
        if (wr_idx_reg >= rd_idx_reg)
        begin
            used_diff = {1'b0, wr_idx_reg} - {1'b0, rd_idx_reg};
        end
        else
        begin
            used_diff = {1'b0, wr_idx_reg} + DEPTH_W - {1'b0, rd_idx_reg};
        end
        used = used_diff[IW-1:0];
        free = LAST_SLOT - used;
    end

    always_comb
    begin
        status.is_pull    = (op_reg == OP_PULL);
        status.empty      = (rd_idx_reg == wr_idx_reg);
        status.full       = (free == '0);
        status.in_limits  = (code_reg >= lower_reg) && (code_reg <= upper_reg);
        status.count_zero = (left_reg == '0);
        status.last_copy  = (left_reg == COUNT_W'(1)) || (free == IW'(1));
    end

    always_comb
    begin
        rd_idx_next  = rd_idx_reg;
        wr_idx_next  = wr_idx_reg;
        lower_next   = lower_reg;
        upper_next   = upper_reg;
        op_next      = op_reg;
        code_next    = code_reg;
        left_next    = left_reg;
        written_next = written_reg;
        pull_ok_next = pull_ok_reg;
        empty_next   = empty_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_LOWER_LIMIT: lower_next = cfg_data;
                REG_UPPER_LIMIT: upper_next = cfg_data;
                default:         lower_next = lower_reg;
            endcase
        end

        if (cmd.load)
        begin
            op_next      = op;
            code_next    = sound_code;
            left_next    = repeat_count;
            written_next = '0;
            pull_ok_next = 1'b0;
            empty_next   = 1'b0;
        end

        if (cmd.mark_empty)
        begin
            empty_next = 1'b1;
        end

        if (cmd.pull_read)
        begin
            pull_ok_next = 1'b1;
            rd_idx_next  = (rd_idx_reg == LAST_SLOT) ? '0 : rd_idx_reg + IW'(1);
        end

        if (cmd.write_copy)
        begin
            wr_idx_next  = (wr_idx_reg == LAST_SLOT) ? '0 : wr_idx_reg + IW'(1);
            left_next    = left_reg - COUNT_W'(1);
            written_next = written_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            lower_reg   <= RESET_LOWER;
            upper_reg   <= RESET_UPPER;
            op_reg      <= OP_PUSH;
            pull_ok_reg <= 1'b0;
            empty_reg   <= 1'b0;
        end
        else
        begin
            rd_idx_reg  <= rd_idx_next;
            wr_idx_reg  <= wr_idx_next;
            lower_reg   <= lower_next;
            upper_reg   <= upper_next;
            op_reg      <= op_next;
            pull_ok_reg <= pull_ok_next;
            empty_reg   <= empty_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        left_reg    <= left_next;
        written_reg <= written_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.write_copy)
        begin
            entry_mem[wr_idx_reg] <= code_reg;
        end
        if (cmd.pull_read)
        begin
            rdata_reg <= entry_mem[rd_idx_reg];
        end
    end

    // free count widened or kept, then its low six bits reported
    assign free_ext = FW'(free);

    assign pulled_code     = pull_ok_reg ? rdata_reg : EMPTY_CODE;
    assign queue_was_empty = empty_reg;
    assign copies_written  = written_reg[OUT6_W-1:0];
    assign free_space      = free_ext[OUT6_W-1:0];

endmodule

// ----- design/sound_command_ring_queue.sv -----
// ----------------------------------------------------------------------------
// sound_command_ring_queue
// ring queue of 16-bit sound codes with repeat pushes and limit checks
// ----------------------------------------------------------------------------
//
// channel   signals                                       direction  handshake
// -------   --------------------------------------------  ---------  ----------------
// command   start, op, sound_code, repeat_count, busy     in         start && !busy
// result    done, pulled_code, queue_was_empty,           out        done, one cycle
//           copies_written, free_space
// config    cfg_valid, cfg_ready, cfg_index, cfg_data     in         cfg_valid && cfg_ready
//
// a pull or a push that writes nothing goes through the evaluate and result
// states before the next possible start; a push that writes n copies also runs
// the copy loop, which writes one entry a cycle through the single memory port
// done is high in the result state; busy falls in the cycle after it
// reset clears indices and restores the limits; memory contents are left as is
// the result cannot be stalled, and config writes are always ready
//
module sound_command_ring_queue #(
    parameter int DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [scrq_pkg::CODE_W-1:0]         sound_code,
    input  logic [scrq_pkg::COUNT_W-1:0]        repeat_count,
    output logic                                done,
    output logic [scrq_pkg::CODE_W-1:0]         pulled_code,
    output logic                                queue_was_empty,
    output logic [scrq_pkg::OUT6_W-1:0]         copies_written,
    output logic [scrq_pkg::OUT6_W-1:0]         free_space,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scrq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scrq_pkg::CODE_W-1:0]         cfg_data
);
    import scrq_pkg::*;

    cmd_t    cmd;
    status_t status;

    // limits can be written at any time, no back-pressure needed
    assign cfg_ready = 1'b1;

    // sequencer: idle, evaluate the item, copy loop, result cycle
    scrq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // memory, indices, limits and result fields
    scrq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .op              (op),
        .sound_code      (sound_code),
        .repeat_count    (repeat_count),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pulled_code     (pulled_code),
        .queue_was_empty (queue_was_empty),
        .copies_written  (copies_written),
        .free_space      (free_space)
    );

endmodule

// ----- tb/sv/scrq_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scrq_tb_pkg
// result predictor and checker for the sound command ring queue testbench
// ----------------------------------------------------------------------------
package scrq_tb_pkg;

    import scrq_pkg::*;

    localparam int RING_DEPTH = 64;

    typedef logic [5:0] slot_t;

    typedef struct {
        logic [CODE_W-1:0] pulled;
        logic              empty;
        logic [OUT6_W-1:0] copies;
        logic [OUT6_W-1:0] space;
    } ring_result_t;

    class ring_queue_scoreboard;

        logic [CODE_W-1:0] slot_mem [RING_DEPTH];
        slot_t             head;
        slot_t             tail;
        logic [CODE_W-1:0] lower;
        logic [CODE_W-1:0] upper;
        ring_result_t      awaited [$];
        int                errors;
        int                items;
        int                empty_pulls;
        int                refused_pushes;
        int                copies_total;
        int                reg_writes;

        function new();
            head           = '0;
            tail           = '0;
            lower          = RESET_LOWER;
            upper          = RESET_UPPER;
            errors         = 0;
            items          = 0;
            empty_pulls    = 0;
            refused_pushes = 0;
            copies_total   = 0;
            reg_writes     = 0;
        endfunction

        // one slot always stays unused, so head == tail means empty
        function slot_t space_left();
            return slot_t'(RING_DEPTH - 1) - slot_t'(tail - head);
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CODE_W-1:0] data);
            if (idx == REG_LOWER_LIMIT)
                lower = data;
            else if (idx == REG_UPPER_LIMIT)
                upper = data;
            reg_writes++;
        endfunction

        function void note_item(logic op_v, logic [CODE_W-1:0] code_v,
                                logic [COUNT_W-1:0] count_v);
            ring_result_t want;
            int           n;
            want.pulled = EMPTY_CODE;
            want.empty  = 1'b0;
            want.copies = '0;
            n           = 0;
            items++;
            if (op_v == OP_PULL) begin
                if (head == tail) begin
                    want.empty = 1'b1;
                    empty_pulls++;
                end
                else begin
                    want.pulled = slot_mem[head];
                    head++;
                end
            end
            else if (space_left() != 0 && code_v >= lower && code_v <= upper) begin
                // copies stop early once the ring fills
                while (n < int'(count_v) && space_left() != 0) begin
                    slot_mem[tail] = code_v;
                    tail++;
                    n++;
                end
                want.copies = OUT6_W'(n);
                copies_total += n;
            end
            else begin
                refused_pushes++;
            end
            want.space = space_left();
            awaited.push_back(want);
        endfunction

        function void check_result(logic [CODE_W-1:0] pulled, logic empty,
                                   logic [OUT6_W-1:0] copies, logic [OUT6_W-1:0] space);
            ring_result_t want;
            if (awaited.size() == 0) begin
                $error("result with no item outstanding: pulled_code %h free_space %0d",
                       pulled, space);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (pulled !== want.pulled) begin
                $error("pulled_code expected %h actual %h", want.pulled, pulled);
                errors++;
            end
            if (empty !== want.empty) begin
                $error("queue_was_empty expected %b actual %b", want.empty, empty);
                errors++;
            end
            if (copies !== want.copies) begin
                $error("copies_written expected %0d actual %0d", want.copies, copies);
                errors++;
            end
            if (space !== want.space) begin
                $error("free_space expected %0d actual %0d", want.space, space);
                errors++;
            end
        endfunction

    endclass

endpackage

// ----- tb/sv/sound_command_ring_queue_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sound_command_ring_queue_test
// self-checking bench: directed corner items then random push and pull
// traffic under several limit settings, every result checked field by field
// against a behavioural ring queue kept alongside the block
// ----------------------------------------------------------------------------
module sound_command_ring_queue_test;

    import scrq_pkg::*;
    import scrq_tb_pkg::*;

    // indexes outside the register map, the block must ignore writes to them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // longest quiet stretch allowed: a full 63-copy push plus the longest
    // hold-off fits well inside this many times over
    localparam int STALL_LIMIT = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 op;
    logic [CODE_W-1:0]    sound_code;
    logic [COUNT_W-1:0]   repeat_count;
    logic                 done;
    logic [CODE_W-1:0]    pulled_code;
    logic                 queue_was_empty;
    logic [OUT6_W-1:0]    copies_written;
    logic [OUT6_W-1:0]    free_space;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CODE_W-1:0]    cfg_data;

    ring_queue_scoreboard board = new();

    sound_command_ring_queue #(
        .DEPTH (RING_DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .sound_code      (sound_code),
        .repeat_count    (repeat_count),
        .done            (done),
        .pulled_code     (pulled_code),
        .queue_was_empty (queue_was_empty),
        .copies_written  (copies_written),
        .free_space      (free_space),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // every result is checked at the edge that ends its strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            board.check_result(pulled_code, queue_was_empty, copies_written, free_space);
    end

    // watchdog: counts edges with no item, result or register write moving
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("sound_command_ring_queue regression: fail");
        $finish;
    end

    // mostly back to back, often a short pause, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // codes lean towards the accepted window and its edges
    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 65 && board.lower <= board.upper)
            return CODE_W'($urandom_range(board.upper, board.lower));
        else if (r < 85) begin
            case ($urandom_range(3))
                0:       return board.lower;
                1:       return board.upper;
                2:       return board.lower - 1'b1;
                default: return board.upper + 1'b1;
            endcase
        end
        else
            return CODE_W'($urandom());
    endfunction

    // short repeats most of the time, the odd long one to fill the ring
    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return COUNT_W'($urandom_range(1, 3));
        else if (r < 70)
            return '0;
        else if (r < 92)
            return COUNT_W'($urandom_range(4, 20));
        else
            return COUNT_W'($urandom_range(255));
    endfunction

    // start stays high across back-to-back items; it only drops for a pause
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic send_item(input logic op_v, input logic [CODE_W-1:0] code_v,
                             input logic [COUNT_W-1:0] count_v);
        @(negedge clk);
        start        <= 1'b1;
        op           <= op_v;
        sound_code   <= code_v;
        repeat_count <= count_v;
        // the item goes in at the first edge that finds the block free
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.note_item(op_v, code_v, count_v);
    endtask

    // drop start and wait for every outstanding result and for busy to clear
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (board.awaited.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        board.write_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // a run of random items; pull_pct sets how hard the ring is drained,
    // steady turns off every pause on the command side
    task automatic run_traffic(input int count, input int pull_pct, input bit steady);
        int                 k;
        logic               op_v;
        logic [CODE_W-1:0]  code_v;
        logic [COUNT_W-1:0] count_v;
        for (k = 0; k < count; k++) begin
            op_v    = ($urandom_range(99) < pull_pct) ? OP_PULL : OP_PUSH;
            code_v  = pick_code();
            count_v = pick_count();
            if (!steady)
                hold_off(pick_gap());
            send_item(op_v, code_v, count_v);
        end
    endtask

    initial
    begin
        // every input known from time zero
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_PUSH;
        sound_code   = '0;
        repeat_count = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_LOWER_LIMIT;
        cfg_data     = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset limits: pull on an empty ring, both window edges, codes just
        // outside it, zero repeat count
        send_item(OP_PULL, 16'h0000, 8'h00);
        send_item(OP_PUSH, RESET_LOWER, 8'd1);
        send_item(OP_PUSH, RESET_UPPER, 8'd1);
        send_item(OP_PUSH, RESET_LOWER - 1'b1, 8'd3);
        send_item(OP_PUSH, RESET_UPPER + 1'b1, 8'd3);
        send_item(OP_PUSH, 16'h0200, 8'd0);
        send_item(OP_PULL, 16'h0000, 8'h00);
        send_item(OP_PULL, 16'h0000, 8'h00);
        send_item(OP_PULL, 16'h0000, 8'h00);

        // largest repeat count fills the ring and stops at 63 copies, then a
        // push into a full ring, a pull whose code and count are ignored, and
        // a two-copy push that only has room for one
        send_item(OP_PUSH, 16'h1234, 8'hFF);
        send_item(OP_PUSH, 16'h0300, 8'd1);
        send_item(OP_PULL, 16'hFFFF, 8'hFF);
        send_item(OP_PUSH, 16'h0400, 8'd2);

        // widest window, a spare register index written and ignored
        settle();
        write_reg(REG_LOWER_LIMIT, 16'h0000);
        write_reg(REG_UPPER_LIMIT, 16'hFFFF);
        write_reg(REG_SPARE_A, 16'hA5A5);
        send_item(OP_PULL, 16'h0000, 8'h00);
        send_item(OP_PULL, 16'h0000, 8'h00);
        send_item(OP_PUSH, 16'h0000, 8'd1);
        send_item(OP_PUSH, 16'hFFFF, 8'd1);
        run_traffic(40, 90, 1'b0);
        run_traffic(40, 50, 1'b1);

        // a window of one code
        settle();
        cfg_data <= cfg_data;
        begin : narrow
            logic [CODE_W-1:0] only_code;
            only_code = CODE_W'($urandom());
            write_reg(REG_LOWER_LIMIT, only_code);
            write_reg(REG_UPPER_LIMIT, only_code);
        end
        write_reg(REG_SPARE_B, CODE_W'($urandom()));
        run_traffic(40, 40, 1'b0);
        run_traffic(40, 70, 1'b0);

        // lower above upper: every push is refused, pulls drain what is left
        settle();
        write_reg(REG_LOWER_LIMIT, 16'hFFFF);
        write_reg(REG_UPPER_LIMIT, 16'h0000);
        run_traffic(40, 30, 1'b0);

        // random windows, either order
        repeat (2) begin
            settle();
            write_reg(REG_LOWER_LIMIT, CODE_W'($urandom()));
            write_reg(REG_UPPER_LIMIT, CODE_W'($urandom()));
            run_traffic(60, 45, 1'b0);
        end

        // back to the reset window
        settle();
        write_reg(REG_LOWER_LIMIT, RESET_LOWER);
        write_reg(REG_UPPER_LIMIT, RESET_UPPER);
        run_traffic(30, 55, 1'b1);
        run_traffic(30, 35, 1'b0);

        // drain the last results, then a short quiet tail for strays
        settle();
        repeat (6) @(posedge clk);

        $display("covered %0d items and %0d register writes: %0d copies queued,",
                 board.items, board.reg_writes, board.copies_total);
        $display("%0d pushes refused, %0d pulls found the ring empty",
                 board.refused_pushes, board.empty_pulls);
        if (board.errors == 0)
            $display("sound_command_ring_queue regression: pass");
        else
            $display("sound_command_ring_queue regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
design/scrq_pkg.sv
design/scrq_ctrl.sv
design/scrq_datapath.sv
design/sound_command_ring_queue.sv
tb/sv/scrq_tb_pkg.sv
tb/sv/sound_command_ring_queue_test.sv
